/* hw/rtl/ngi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngi_pkg: shared types and constants of the nonuniform grid interpolator
// Modes, status codes, configuration indexes, controller states.
// ----------------------------------------------------------------------------
package ngi_pkg;

  localparam int unsigned MaxPointsDef = 16;
  localparam int unsigned GridDepthDef = 4096;
  localparam int unsigned NumAxes      = 3;

  typedef enum logic [1:0] {
    MODE_WR_BP   = 2'd0,
    MODE_WR_GRID = 2'd1,
    MODE_EVAL    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_WRNG = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_AXIS  = 2'd0,
    CFG_SIZE0 = 2'd1,
    CFG_SIZE1 = 2'd2,
    CFG_SIZE2 = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DIVSTART,
    S_DIV,
    S_ADDR,
    S_FETCH,
    S_FETCHW,
    S_BLEND,
    S_BLENDW,
    S_OUT
  } state_e;

  // handshake between controller and a lane divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

/* hw/rtl/nonuniform_grid_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonuniform_grid_interpolator: 1/2/3-axis table interpolator
// Three axis lanes search and divide in parallel; a sequencer fetches the
// corners from the grid memory and folds them through one blend unit.
// ----------------------------------------------------------------------------
// One item at a time. An evaluation runs a breakpoint scan (one breakpoint
// memory read a cycle per lane), starts and runs the bit-serial weight
// dividers, reads each corner from the grid memory, takes the blend steps
// and then presents the result. A zero-width segment ends the item right
// after the scan. No clearing pass is needed.
module nonuniform_grid_interpolator #(
  parameter int unsigned MaxPoints = ngi_pkg::MaxPointsDef,
  parameter int unsigned GridDepth = ngi_pkg::GridDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [1:0]         axis_sel_i,
  input  logic [3:0]         point_pos_i,
  input  logic [11:0]        grid_addr_i,
  input  logic signed [31:0] write_data_i,
  input  logic signed [31:0] coord_first_i,
  input  logic signed [31:0] coord_second_i,
  input  logic signed [31:0] coord_third_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] interp_value_o,
  output logic [1:0]         status_o
);
  import ngi_pkg::*;

  localparam int unsigned PW = $clog2(MaxPoints);
  localparam int unsigned GW = $clog2(GridDepth);

  // configuration registers
  logic [1:0] axis_q;
  logic [4:0] sz_q [NumAxes];
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= 2'd1; sz_q[0] <= 5'd2; sz_q[1] <= 5'd1; sz_q[2] <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_AXIS:  axis_q   <= cfg_data_i[1:0];
        CFG_SIZE0: sz_q[0] <= cfg_data_i[4:0];
        CFG_SIZE1: sz_q[1] <= cfg_data_i[4:0];
        CFG_SIZE2: sz_q[2] <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [1:0] naxes;
  assign naxes = (axis_q == 2'd0) ? 2'd1 : axis_q;
  logic [PW:0] nsz [NumAxes];
  logic [PW:0] ncl [NumAxes];   // size as used in addressing (1 if inactive)
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      if (32'(sz_q[a]) < 32'd2) nsz[a] = (PW+1)'(2);
      else if (32'(sz_q[a]) > MaxPoints) nsz[a] = (PW+1)'(MaxPoints);
      else nsz[a] = (PW+1)'(sz_q[a]);
      ncl[a] = (a == 0 || 32'(naxes) > 32'(a)) ? nsz[a] : (PW+1)'(1);
    end
  end

  state_e st_q, st_d;
  logic [1:0] stat_q, stat_d;
  logic signed [31:0] res_q, res_d;
  logic outv_q, outv_d;
  logic [3:0] k_q, k_d;
  logic sat_q, sat_d;
  logic signed [31:0] v_q [8];
  logic [1:0] bax_q, bax_d;

  logic accept;
  assign in_ready_o = (st_q == S_IDLE) && !outv_q;
  assign accept = in_valid_i && in_ready_o;

  // lanes
  logic coords_ok;
  logic [NumAxes-1:0] found, zero, lsat, busy;
  logic [PW-1:0] seg [NumAxes];
  logic signed [31:0] wgt [NumAxes];
  div_ctl_t dci, dco [NumAxes];
  logic signed [31:0] crd [NumAxes];
  assign crd[0] = coord_first_i;
  assign crd[1] = coord_second_i;
  assign crd[2] = coord_third_i;
  assign coords_ok = accept && (mode_i == MODE_EVAL);
  assign dci.busy = 1'b0;
  assign dci.start = (st_q == S_DIVSTART);

  logic wr_ok_bp;
  assign wr_ok_bp = accept && mode_i == MODE_WR_BP && axis_sel_i <= 2'd2
                    && 32'(point_pos_i) < MaxPoints;

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    ngi_lane #(.MaxPoints(MaxPoints)) u_lane (
      .clk_i, .rst_ni,
      .wr_i         (wr_ok_bp && axis_sel_i == 2'(a)),
      .wr_pos_i     (PW'(point_pos_i)),
      .wr_data_i    (write_data_i),
      .scan_start_i (coords_ok),
      .coord_i      (crd[a]),
      .size_i       (nsz[a]),
      .div_i        (dci),
      .found_o      (found[a]),
      .seg_o        (seg[a]),
      .zero_o       (zero[a]),
      .div_o        (dco[a]),
      .weight_o     (wgt[a]),
      .sat_o        (lsat[a])
    );
    assign busy[a] = dco[a].busy;
  end

  logic [NumAxes-1:0] act;
  always_comb for (int a = 0; a < NumAxes; a++) act[a] = (a == 0) || 32'(naxes) > 32'(a);

  // grid memory
  logic [31:0] grid_mem [GridDepth];
  logic [31:0] grid_rd_q;
  logic [GW-1:0] gaddr;
  logic [31:0] caddr;
  logic crange_q;
  logic wr_ok_grid;
  assign wr_ok_grid = accept && mode_i == MODE_WR_GRID && 32'(grid_addr_i) < GridDepth;
  always_ff @(posedge clk_i) begin
    if (wr_ok_grid) grid_mem[GW'(grid_addr_i)] <= write_data_i;
    grid_rd_q <= grid_mem[gaddr];
  end

  // corner address for corner k
  always_comb begin
    logic [31:0] p0, p1, p2;
    p0 = 32'(seg[0]) + 32'(k_q[0]);
    p1 = act[1] ? 32'(seg[1]) + 32'(k_q[1]) : 32'd0;
    p2 = act[2] ? 32'(seg[2]) + 32'(k_q[2]) : 32'd0;
    caddr = (p0 * 32'(ncl[1]) + p1) * 32'(ncl[2]) + p2;
    gaddr = GW'(caddr);
  end

  // blend unit: pair j with j + half, j = k_q index
  logic [2:0] half;
  logic signed [31:0] bl_r;
  logic bl_sat;
  assign half = 3'd1 << bax_q;
  ngi_blend u_blend (
    .clk_i (clk_i),
    .a_i   (v_q[k_q[2:0]]),
    .b_i   (v_q[3'(k_q[2:0] + half)]),
    .t_i   (wgt[bax_q]),
    .r_o   (bl_r),
    .sat_o (bl_sat)
  );

  logic [3:0] ncorner;
  assign ncorner = 4'd1 << naxes;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:     if (accept) st_d = (mode_i == MODE_EVAL) ? S_SEARCH : S_OUT;
      S_SEARCH:   if (&(found | ~act)) st_d = (|(zero & act)) ? S_OUT : S_DIVSTART;
      S_DIVSTART: st_d = S_DIV;
      S_DIV:      if (!(|busy)) st_d = S_ADDR;
      S_ADDR:     st_d = S_FETCH;
      S_FETCH:    st_d = S_FETCHW;
      S_FETCHW:   st_d = (k_q + 4'd1 == ncorner) ? S_BLEND : S_ADDR;
      S_BLEND:    st_d = S_BLENDW;
      S_BLENDW: begin
        if (3'(k_q + 4'd1) != half) st_d = S_BLEND;
        else if (bax_q == 2'd0) st_d = S_OUT;
        else st_d = S_BLEND;
      end
      S_OUT:      st_d = S_IDLE;
      default:    st_d = S_IDLE;
    endcase
  end

  // datapath / outputs
  always_comb begin
    stat_d = stat_q; res_d = res_q; outv_d = outv_q;
    k_d = k_q; sat_d = sat_q; bax_d = bax_q;
    if (outv_q && out_ready_i) outv_d = 1'b0;
    unique case (st_q)
      S_IDLE: if (accept) begin
        res_d = '0; stat_d = ST_OK; sat_d = 1'b0; k_d = '0;
        if (mode_i == MODE_WR_BP && !wr_ok_bp) stat_d = ST_WRNG;
        if (mode_i == MODE_WR_GRID && !wr_ok_grid) stat_d = ST_WRNG;
      end
      S_SEARCH: if (&(found | ~act) && |(zero & act)) stat_d = ST_ZERO;
      S_DIV: if (!(|busy)) begin
        sat_d = |(lsat & act); k_d = '0;
      end
      S_FETCHW: begin
        k_d = k_q + 4'd1;
        if (k_q + 4'd1 == ncorner) begin k_d = '0; bax_d = 2'(naxes - 2'd1); end
      end
      S_BLENDW: begin
        sat_d = sat_q | bl_sat;
        k_d = k_q + 4'd1;
        if (3'(k_q + 4'd1) == half) begin
          k_d = '0;
          if (bax_q == 2'd0) begin
            res_d = bl_r; stat_d = (sat_q | bl_sat) ? ST_SAT : ST_OK;
          end else bax_d = bax_q - 2'd1;
        end
      end
      S_OUT: outv_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; outv_q <= 1'b0; k_q <= '0; bax_q <= '0;
    end else begin
      st_q <= st_d; outv_q <= outv_d; k_q <= k_d; bax_q <= bax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d; res_q <= res_d; sat_q <= sat_d;
    if (st_q == S_FETCH) crange_q <= caddr < GridDepth;
    if (st_q == S_FETCHW) v_q[k_q[2:0]] <= crange_q ? grid_rd_q : 32'd0;
    if (st_q == S_BLENDW) v_q[k_q[2:0]] <= bl_r;
  end

  assign out_valid_o = outv_q;
  assign interp_value_o = res_q;
  assign status_o = stat_q;

endmodule

/* hw/rtl/ngi_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngi_div: per-axis weight unit
// Restoring radix-2 divider forming a rounded, clamped Q.16 weight.
// ----------------------------------------------------------------------------
module ngi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] num_i,   // c - x0
  input  logic signed [32:0] den_i,   // x1 - x0, nonzero
  output logic               busy_o,
  output logic signed [31:0] weight_o,
  output logic               sat_o
);
  import ngi_pkg::*;

  localparam int unsigned NW = 50;  // |num| << 16 plus rounding half

  logic [NW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [32:0]   den_q, den_d;
  logic          neg_q, neg_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [32:0]   mag_n, mag_w;
  logic [NW:0]   trial;
  logic [NW-1:0] shifted;

  assign mag_n = num_i[32] ? 33'(-num_i) : 33'(num_i);
  assign mag_w = den_i[32] ? 33'(-den_i) : 33'(den_i);

  // one quotient bit per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    shifted = {rem_q[NW-2:0], quo_q[NW-1]};
    trial  = {1'b0, shifted} - {{(NW-32){1'b0}}, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = {1'b0, mag_n, 16'd0} + NW'(mag_w >> 1);
      den_d  = mag_w;
      neg_d  = num_i[32] ^ den_i[32];
      cnt_d  = 6'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[NW]) rem_d = trial[NW-1:0];
      else            rem_d = shifted;
      quo_d = {quo_q[NW-2:0], ~trial[NW]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // clamp to 2^30 and apply sign
  logic [30:0] qc;
  always_comb begin
    sat_o = quo_q > NW'(32'h4000_0000);
    qc    = sat_o ? 31'h4000_0000 : quo_q[30:0];
    weight_o = neg_q ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end
  assign busy_o = busy_q;

endmodule

/* hw/rtl/ngi_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngi_lane: one axis lane
// Holds the breakpoints of one axis, finds the segment by a linear scan and
// forms the weight through its own divider.
// ----------------------------------------------------------------------------
module ngi_lane #(
  parameter int unsigned MaxPoints = ngi_pkg::MaxPointsDef,
  localparam int unsigned PW = $clog2(MaxPoints)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  logic [PW-1:0]      wr_pos_i,
  input  logic [31:0]        wr_data_i,
  input  logic               scan_start_i,  // loads coordinate, resets scan
  input  logic signed [31:0] coord_i,
  input  logic [PW:0]        size_i,        // clamped 2..MaxPoints
  input  ngi_pkg::div_ctl_t  div_i,
  output logic               found_o,
  output logic [PW-1:0]      seg_o,
  output logic               zero_o,
  output ngi_pkg::div_ctl_t  div_o,
  output logic signed [31:0] weight_o,
  output logic               sat_o
);
  import ngi_pkg::*;

  logic [31:0] bp_mem [MaxPoints];
  logic [PW-1:0] rd_addr;
  logic signed [31:0] rd_q;
  logic signed [31:0] first_q, x0_q, coord_q;
  logic [PW:0]   idx_q, idx_d;
  logic [2:0]    ph_q, ph_d;  // scan phase
  logic          found_q, found_d;
  logic [PW-1:0] seg_q, seg_d;
  logic          zero_q;

  // breakpoint store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_i) bp_mem[wr_pos_i] <= wr_data_i;
    rd_q <= bp_mem[rd_addr];
  end

  // phases: 0 read first, 1 judge first and read last, 2 judge last,
  // 3 scan, 4 read x0, 5 read x1, 6 done
  always_comb begin
    idx_d   = idx_q;
    ph_d    = ph_q;
    found_d = found_q;
    seg_d   = seg_q;
    rd_addr = idx_q[PW-1:0];
    unique case (ph_q)
      3'd0: begin rd_addr = '0; ph_d = 3'd1; end
      3'd1: begin
        // rd_q holds the first breakpoint
        rd_addr = PW'(size_i - 1'b1);
        if (coord_q <= rd_q) begin seg_d = '0; ph_d = 3'd4; end
        else ph_d = 3'd2;
      end
      3'd2: begin
        // rd_q holds the last breakpoint
        if (coord_q >= rd_q) begin seg_d = PW'(size_i - 2'd2); ph_d = 3'd4; end
        else begin idx_d = (PW+1)'(1); rd_addr = PW'(1); ph_d = 3'd3; end
      end
      3'd3: begin
        // rd_q holds bp[idx_q]; its address was issued in the cycle before
        rd_addr = PW'(idx_q + 1'b1);
        if (coord_q < rd_q) begin seg_d = PW'(idx_q - 1'b1); ph_d = 3'd4; end
        else if (idx_q + 1'b1 >= size_i) begin seg_d = '0; ph_d = 3'd4; end
        else idx_d = idx_q + 1'b1;
      end
      3'd4: begin rd_addr = seg_q; ph_d = 3'd5; end
      3'd5: begin rd_addr = PW'(seg_q + 1'b1); ph_d = 3'd6; end
      3'd6: begin rd_addr = PW'(seg_q + 1'b1); found_d = 1'b1; end
      default: ;
    endcase
    if (scan_start_i) begin
      ph_d = 3'd0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= 3'd6;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      ph_q    <= ph_d;
      found_q <= found_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    if (scan_start_i) coord_q <= coord_i;
    if (ph_q == 3'd5) x0_q <= rd_q;
    if (ph_q == 3'd6 && !found_q) zero_q <= (rd_q == x0_q);
    if (ph_q == 3'd6 && !found_q) first_q <= rd_q;  // x1
  end

  ngi_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_i.start),
    .num_i    (33'(coord_q) - 33'(x0_q)),
    .den_i    (33'(first_q) - 33'(x0_q)),
    .busy_o   (div_o.busy),
    .weight_o (weight_o),
    .sat_o    (sat_o)
  );
  assign div_o.start = div_i.start;

  assign found_o = found_q;
  assign seg_o   = seg_q;
  assign zero_o  = zero_q;

endmodule

/* hw/rtl/ngi_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngi_blend: merging stage
// Step r = a + round((b - a) * t) with saturation; the product is registered.
// ----------------------------------------------------------------------------
module ngi_blend (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] t_i,
  output logic signed [31:0] r_o,
  output logic               sat_o
);
  import ngi_pkg::*;

  logic signed [32:0] diff;
  logic signed [64:0] prod_q;
  logic signed [31:0] a_q;
  logic [64:0]        mag;
  logic [48:0]        m;
  logic signed [50:0] r;

  assign diff = 33'(b_i) - 33'(a_i);

  // product registered before the rounding add
  always_ff @(posedge clk_i) begin
    prod_q <= 65'(diff) * 65'(t_i);
    a_q    <= a_i;
  end

  always_comb begin
    mag = prod_q[64] ? 65'(-prod_q) : 65'(prod_q);
    m   = 49'((mag + 65'h8000) >> 16);
    r   = prod_q[64] ? 51'(a_q) - 51'(m) : 51'(a_q) + 51'(m);
    sat_o = 1'b0;
    r_o   = r[31:0];
    if (r > 51'sd2147483647) begin r_o = 32'sh7fff_ffff; sat_o = 1'b1; end
    else if (r < -51'sd2147483648) begin r_o = 32'sh8000_0000; sat_o = 1'b1; end
  end

endmodule
